[hdl/cfp_pkg.sv]
// shared types and constants of the checksummed frame parser
package cfp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h80;
  localparam logic [6:0] SUM_MASK    = 7'h7F;
  localparam logic [1:0] MODE_PARSE  = 2'd2;

  // configuration register indexes
  localparam logic REG_MODE          = 1'b0;
  localparam logic REG_SILENCE_LIMIT = 1'b1;

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    EV_BYTE      = 2'd0,
    EV_CSUM_ERR  = 2'd1,
    EV_LINK_LOST = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HEAD = 3'b010,
    PH_TAIL = 3'b100
  } phase_t;

  // one queued job: a single result, or a burst of the eight head bytes
  typedef struct packed {
    logic            burst;
    event_t          evt;
    logic [4:0]      index;
    logic [7:0][7:0] bytes;
    logic            link_up;
    logic            last;
  } job_t;

endpackage

[hdl/cfp_front.sv]
// frame parser front end: classifies bytes and ticks, keeps link state, queues jobs
module cfp_front import cfp_pkg::*; #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  localparam logic [5:0] FRAME_LEN_W = 6'(FRAME_LEN);

  logic [1:0]      mode_r, mode_nxt;
  logic [15:0]     limit_r, limit_nxt;
  phase_t          phase_r, phase_nxt;
  logic [4:0]      pos_r, pos_nxt;
  logic [6:0]      sum_r, sum_nxt;
  logic            avail_r, avail_nxt;
  logic [15:0]     silence_r, silence_nxt;
  logic [7:0][7:0] head_r;
  logic            head_we;
  logic [2:0]      head_addr;
  logic            acc;
  logic [5:0]      pos_inc;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign pos_inc   = {1'b0, pos_r} + 6'd1;

  always_comb begin
    mode_nxt    = mode_r;
    limit_nxt   = limit_r;
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    avail_nxt   = avail_r;
    silence_nxt = silence_r;
    head_we     = 1'b0;
    head_addr   = pos_r[2:0];
    q_push      = 1'b0;
    q_job       = '0;
    q_job.evt   = EV_BYTE;
    q_job.link_up = avail_r;

    if (cfg_valid) begin
      if (cfg_index == REG_MODE) begin
        mode_nxt = cfg_data[1:0];
        if (cfg_data[1:0] != mode_r) begin
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
          sum_nxt   = '0;
        end
      end else begin
        limit_nxt = cfg_data;
      end
    end

    if (acc && mode_r == MODE_PARSE) begin
      if (in_tuser) begin
        // periodic tick
        if (silence_r > limit_r) begin
          if (avail_r) begin
            avail_nxt     = 1'b0;
            q_push        = 1'b1;
            q_job.evt     = EV_LINK_LOST;
            q_job.link_up = 1'b0;
            q_job.last    = 1'b1;
          end
        end else if (silence_r != 16'hFFFF) begin
          silence_nxt = silence_r + 16'd1;
        end
      end else begin
        case (phase_r)
          PH_HUNT: begin
            if (in_tdata == HEADER_BYTE) begin
              head_we   = 1'b1;
              head_addr = 3'd0;
              pos_nxt   = 5'd1;
              sum_nxt   = '0;
              phase_nxt = PH_HEAD;
            end
          end
          PH_HEAD: begin
            if (pos_r < 5'd7) begin
              head_we = 1'b1;
              sum_nxt = (sum_r + in_tdata[6:0]) & SUM_MASK;
              pos_nxt = pos_inc[4:0];
            end else if (in_tdata == {1'b0, sum_r}) begin
              avail_nxt     = 1'b1;
              silence_nxt   = '0;
              q_push        = 1'b1;
              q_job.burst   = 1'b1;
              q_job.link_up = 1'b1;
              q_job.bytes   = head_r;
              q_job.bytes[7] = in_tdata;
              q_job.last    = (FRAME_LEN <= 8);
              if (FRAME_LEN <= 8) begin
                phase_nxt = PH_HUNT;
                pos_nxt   = '0;
                sum_nxt   = '0;
              end else begin
                phase_nxt = PH_TAIL;
                pos_nxt   = 5'd8;
              end
            end else begin
              q_push      = 1'b1;
              q_job.evt   = EV_CSUM_ERR;
              q_job.index = 5'd7;
              q_job.bytes[0] = in_tdata;
              q_job.last  = 1'b1;
              phase_nxt   = PH_HUNT;
              pos_nxt     = '0;
              sum_nxt     = '0;
            end
          end
          PH_TAIL: begin
            q_push         = 1'b1;
            q_job.index    = pos_r;
            q_job.bytes[0] = in_tdata;
            q_job.last     = (pos_inc >= FRAME_LEN_W);
            if (pos_inc >= FRAME_LEN_W) begin
              phase_nxt = PH_HUNT;
              pos_nxt   = '0;
              sum_nxt   = '0;
            end else begin
              pos_nxt = pos_inc[4:0];
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      limit_r   <= 16'd100;
      phase_r   <= PH_HUNT;
      pos_r     <= '0;
      sum_r     <= '0;
      avail_r   <= 1'b0;
      silence_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      limit_r   <= limit_nxt;
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      avail_r   <= avail_nxt;
      silence_r <= silence_nxt;
    end
  end

  // head bytes need no reset, each is written before the frame that reads it
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_r[head_addr] <= in_tdata;
    end
  end

endmodule

[hdl/cfp_queue.sv]
// short job queue between the front end and the output sequencer
module cfp_queue import cfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCOUNT_W-1:0] count_r, count_nxt;
  logic                do_pop;

  assign full       = (count_r == QCOUNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + QCOUNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - QCOUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hdl/cfp_back.sv]
// output sequencer: expands queued jobs into result transactions
module cfp_back import cfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic       valid_r;
  logic [2:0] cnt_r;
  event_t     evt_r;
  logic [4:0] index_r;
  logic [7:0] value_r;
  logic       link_r;
  logic       last_r;
  logic       load;

  assign load  = !valid_r || out_tready;
  assign q_pop = load && q_valid && (!q_job.burst || cnt_r == 3'd7);

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, link_r, value_r, index_r};
  assign out_tuser  = evt_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (load) begin
      valid_r <= q_valid;
      if (q_valid && q_job.burst) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      evt_r  <= q_job.evt;
      link_r <= q_job.link_up;
      if (q_job.burst) begin
        index_r <= {2'b00, cnt_r};
        value_r <= q_job.bytes[cnt_r];
        last_r  <= q_job.last && (cnt_r == 3'd7);
      end else begin
        index_r <= q_job.index;
        value_r <= q_job.bytes[0];
        last_r  <= q_job.last;
      end
    end
  end

endmodule

[hdl/checksummed_frame_parser_core.sv]
// checksummed frame parser top level: front end, job queue, output sequencer
//
//  channel  | dir | handshake              | payload
//  in_      | in  | in_tvalid/in_tready    | tdata rx_byte, tuser kind
//  out_     | out | out_tvalid/out_tready  | tdata index/value/link_up, tuser event, tlast
//  cfg_     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// one input transaction per cycle while the job queue is not full; a good frame gives
// its eight head bytes in order from the output sequencer, every other result is one.
// a result passes through the job queue and the output register before it is offered.
// rst_n is synchronous; the parser comes up idle in mode 0.
// the four-entry job queue lets input continue while the output is stalled;
// input stalls while it is full, as it can be behind a head burst.
module checksummed_frame_parser_core import cfp_pkg::*; #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] byte_index, [12:5] byte_value, [13] link_up
  output logic [1:0]  out_tuser,  // [1:0] event_res
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  assign cfg_ready = 1'b1;

  cfp_front #(
    .FRAME_LEN (FRAME_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  cfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  cfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[hdl/cfp_checker.sv]
// port-level checks of the checksummed frame parser
module cfp_checker import cfp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // link-lost reports a down link and ends its own run
  a_lost_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_LINK_LOST |-> out_tlast && !out_tdata[13]
      && out_tdata[12:0] == 13'd0)
    else $error("bad link-lost transaction");

  // checksum errors always point at the check byte
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_CSUM_ERR |-> out_tlast && out_tdata[4:0] == 5'd7)
    else $error("bad checksum-error transaction");

  // head bytes follow a good check byte, so they always come with the link up
  a_byte_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_BYTE && out_tdata[4:0] < 5'd8 |-> out_tdata[13])
    else $error("head byte with link down");

  // a non-final head byte is followed by the next index
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == EV_BYTE && !out_tlast
      && out_tdata[4:0] < 5'd7 |=> out_tvalid && out_tuser == EV_BYTE
      && out_tdata[4:0] == $past(out_tdata[4:0]) + 5'd1)
    else $error("head bytes out of order");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind checksummed_frame_parser_core cfp_checker u_cfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/sv/frame_result_checker.sv]
// checker for the frame parser: predicts results from observed transactions and compares
module frame_result_checker import cfp_pkg::*; #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned mismatch_count,
  output int unsigned results_pending
);

  typedef struct packed {
    event_t     evt;
    logic [4:0] index;
    logic [7:0] value;
    logic       link_up;
    logic       last;
  } frame_result_t;

  frame_result_t expected_results[$];

  // predicted parser state and registers
  logic [1:0]  mode_q;
  logic [15:0] silence_limit_q;
  phase_t      phase_q;
  logic [4:0]  pos_q;
  logic [6:0]  sum_q;
  logic [7:0]  head_q [8];
  logic        link_q;
  logic [15:0] silence_q;

  task automatic restart_hunt();
    phase_q = PH_HUNT;
    pos_q   = '0;
    sum_q   = '0;
  endtask

  function automatic void push_result(event_t evt, logic [4:0] idx, logic [7:0] val,
                                      logic lst);
    expected_results.push_back('{evt, idx, val, link_q, lst});
  endfunction

  task automatic predict_item(input logic kind, input logic [7:0] rx);
    logic lst;
    if (mode_q != MODE_PARSE) return;
    if (kind) begin
      if (silence_q > silence_limit_q) begin
        if (link_q) begin
          link_q = 1'b0;
          push_result(EV_LINK_LOST, 5'd0, 8'h00, 1'b1);
        end
      end else if (silence_q != 16'hFFFF) begin
        silence_q = silence_q + 16'd1;
      end
      return;
    end
    case (phase_q)
      PH_HUNT: begin
        if (rx == HEADER_BYTE) begin
          head_q[0] = rx;
          pos_q     = 5'd1;
          sum_q     = '0;
          phase_q   = PH_HEAD;
        end
      end
      PH_HEAD: begin
        if (pos_q < 5'd7) begin
          head_q[pos_q[2:0]] = rx;
          sum_q = sum_q + rx[6:0];
          pos_q = pos_q + 5'd1;
        end else begin
          head_q[7] = rx;
          if (rx == {1'b0, sum_q}) begin
            link_q    = 1'b1;
            silence_q = '0;
            for (int i = 0; i < 8; i++)
              push_result(EV_BYTE, 5'(i), head_q[i], (i == 7) && (FRAME_LEN <= 8));
            if (FRAME_LEN <= 8) begin
              restart_hunt();
            end else begin
              phase_q = PH_TAIL;
              pos_q   = 5'd8;
            end
          end else begin
            push_result(EV_CSUM_ERR, 5'd7, rx, 1'b1);
            restart_hunt();
          end
        end
      end
      default: begin
        lst = (int'(pos_q) + 1 >= int'(FRAME_LEN));
        push_result(EV_BYTE, pos_q, rx, lst);
        if (lst) restart_hunt();
        else pos_q = pos_q + 5'd1;
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    frame_result_t seen;
    frame_result_t want;
    if (!rst_n) begin
      mode_q          = '0;
      silence_limit_q = 16'd100;
      restart_hunt();
      foreach (head_q[i]) head_q[i] = '0;
      link_q          = 1'b0;
      silence_q       = '0;
      mismatch_count  = 0;
      expected_results.delete();
    end else begin
      // a result never belongs to an input taken at the same edge
      if (out_tvalid && out_tready) begin
        seen = '{event_t'(out_tuser), out_tdata[4:0], out_tdata[12:5], out_tdata[13],
                 out_tlast};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transaction: expected none, actual ev %0d idx %0d val %02h link %0b last %0b",
                   $time, seen.evt, seen.index, seen.value, seen.link_up, seen.last);
        end else begin
          want = expected_results.pop_front();
          if (seen.evt !== want.evt || seen.index !== want.index ||
              seen.value !== want.value || seen.link_up !== want.link_up ||
              seen.last !== want.last) begin
            mismatch_count++;
            $display("%0t: result mismatch: expected ev %0d idx %0d val %02h link %0b last %0b, actual ev %0d idx %0d val %02h link %0b last %0b",
                     $time, want.evt, want.index, want.value, want.link_up, want.last,
                     seen.evt, seen.index, seen.value, seen.link_up, seen.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) begin
          if (cfg_data[1:0] != mode_q) restart_hunt();
          mode_q = cfg_data[1:0];
        end else begin
          silence_limit_q = cfg_data;
        end
      end
      if (in_tvalid && in_tready)
        predict_item(in_tuser, in_tdata);
    end
    results_pending = expected_results.size();
  end

endmodule

[tb/sv/tb_checksummed_frame_parser_core.sv]
// testbench top for the checksummed frame parser: stimulus, idling and verdict
module tb_checksummed_frame_parser_core import cfp_pkg::*;;

  localparam int unsigned FRAME_LEN    = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 17;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        in_tuser;   // [0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [4:0] byte_index, [12:5] byte_value, [13] link_up
  logic [1:0]  out_tuser;  // [1:0] event_res
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  checksummed_frame_parser_core #(.FRAME_LEN(FRAME_LEN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  frame_result_checker #(.FRAME_LEN(FRAME_LEN)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_pending);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready = ($urandom_range(99) >= recv_stall_pct);

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic kind, input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = rx;
    in_tuser  = kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_data(input logic [7:0] rx, input int unsigned tick_pct);
    if ($urandom_range(99) < tick_pct) send_item(1'b1, 8'($urandom));
    send_item(1'b0, rx);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait until the block has drained everything in flight
  task automatic settle();
    in_tvalid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return HEADER_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // header, six body bytes (lowest byte first) and the check byte
  task automatic send_head(input logic [47:0] body, input logic corrupt,
                           input int unsigned tick_pct);
    logic [6:0] sum;
    logic [7:0] check;
    sum = '0;
    send_data(HEADER_BYTE, tick_pct);
    for (int i = 0; i < 6; i++) begin
      send_data(body[8*i +: 8], tick_pct);
      sum = sum + body[8*i +: 7];
    end
    check = {1'b0, sum};
    if (corrupt) check = check ^ 8'($urandom_range(255, 1));
    send_data(check, tick_pct);
  endtask

  task automatic run_random_phase(input logic [15:0] limit, input int unsigned idle_pct,
                                  input int unsigned stall_pct, input logic toggle_mode);
    int unsigned start_count;
    int unsigned pick;
    logic [47:0] body;
    settle();
    if (toggle_mode) begin
      // leaving and re-entering parse mode restarts the hunt
      write_reg(REG_MODE, {14'($urandom), 2'd1});
      write_reg(REG_MODE, {14'($urandom), MODE_PARSE});
    end
    write_reg(REG_SILENCE_LIMIT, limit);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_count    = items_sent;
    while (items_sent - start_count < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      for (int k = 0; k < 6; k++) body[8*k +: 8] = pick_byte();
      if (pick < 75) begin
        send_head(body, pick >= 60, 8);
        if (pick < 60)
          for (int k = 0; k < int'(FRAME_LEN) - 8; k++) send_data(pick_byte(), 8);
      end else if (pick < 88) begin
        repeat ($urandom_range(4, 1)) send_item(1'b0, pick_byte());
      end else begin
        repeat ($urandom_range(6, 1)) send_item(1'b1, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_MODE;
    cfg_data       = '0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle modes drop bytes and ticks
    send_item(1'b0, HEADER_BYTE);
    send_item(1'b1, 8'h00);
    settle();
    write_reg(REG_MODE, 16'd3);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, HEADER_BYTE);
    settle();
    write_reg(REG_MODE, 16'd1);
    write_reg(REG_SILENCE_LIMIT, 16'hFFFF);
    write_reg(REG_SILENCE_LIMIT, 16'd0);
    write_reg(REG_MODE, {14'd0, MODE_PARSE});
    write_reg(REG_MODE, {14'd0, MODE_PARSE});

    // noise while hunting, then a frame cut short by a mode change
    send_item(1'b0, 8'h00);
    send_item(1'b0, HEADER_BYTE);
    send_item(1'b0, 8'h12);
    settle();
    write_reg(REG_MODE, 16'd1);
    write_reg(REG_MODE, {14'd0, MODE_PARSE});

    // good frame with a header value inside it; rewriting the same mode mid-frame
    send_item(1'b0, HEADER_BYTE);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, HEADER_BYTE);
    send_item(1'b0, 8'h00);
    settle();
    write_reg(REG_MODE, {14'd0, MODE_PARSE});
    send_item(1'b0, 8'h7F);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h55);
    send_item(1'b0, 8'h54);  // low 7 bits of ff+80+00+7f+01+55
    for (int i = 0; i < int'(FRAME_LEN) - 8; i++)
      send_item(1'b0, (i % 2 == 1) ? 8'hFF : 8'(i * 16));

    // silence limit 0: second tick drops the link, third gives nothing
    repeat (3) send_item(1'b1, 8'($urandom));

    // checksum error while the link is down
    send_head({8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06}, 1'b1, 0);

    run_random_phase(16'd2, 0, 0, 1'b0);
    run_random_phase(16'd0, 80, 0, 1'b0);
    run_random_phase(16'd65534, 0, 80, 1'b1);
    run_random_phase(16'($urandom_range(4, 1)), 21, 21, 1'b1);

    settle();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
